FILE: hw/rtl/mthw_pkg.sv
`timescale 1ns / 1ps

package mthw_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // request modes
  localparam logic [1:0] MODE_REGISTER  = 2'd0;
  localparam logic [1:0] MODE_REMOVE    = 2'd1;
  localparam logic [1:0] MODE_HEARTBEAT = 2'd2;
  localparam logic [1:0] MODE_TICK      = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ALARM = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_WALK,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/multi_task_heartbeat_watchdog.sv
`timescale 1ns / 1ps

// Heartbeat watchdog over MAX_SLOTS task slots. Each request on the slave
// stream is register (0), remove (1), heartbeat (2) or tick (3). Register,
// remove and heartbeat change one slot and are answered by one acknowledge
// (tuser = 0, tlast = 1) naming the slot. A tick walks the valid slots from
// the highest index down to 0: a slot that beat since the last tick has its
// flag and missed count cleared, any other has its count raised (saturating).
// Every walked slot whose count then exceeds alarm_limit gives an alarm
// (tuser = 1) with its slot and count; a tick-finished result (tuser = 2,
// tlast = 1) closes the tick. alarm_limit resets to 10; the user must write it
// through cfg_we/cfg_wdata only while the block is idle, as the block itself
// does not enforce this. A request drops tready after acceptance until its
// acknowledge or, for a tick, its tick-finished result is loaded; one shared
// increment/compare step handles one slot per cycle, holding while an alarm
// cannot be handed on. Back-pressure on the master side stretches either.
// The single output register lets a new request be accepted while the last
// result still waits to be taken.
module multi_task_heartbeat_watchdog
  import mthw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: alarm_limit
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] mode, [5:2] task_slot, [6] beat_value
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] alarm_slot, [19:4] missed_ticks
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  // slot table
  logic                  slot_valid [MAX_SLOTS];
  logic                  beat_flag  [MAX_SLOTS];
  logic [COUNT_BITS-1:0] missed_count [MAX_SLOTS];

  logic [15:0]          alarm_limit;
  state_t               state, state_next;
  logic [SLOT_BITS-1:0] walk_idx;
  logic [3:0]           ack_slot;

  // output register
  logic                  out_valid;
  logic [1:0]            out_kind;
  logic [3:0]            out_slot;
  logic [15:0]           out_missed;
  logic                  out_last;

  // request fields
  logic [1:0]           req_mode;
  logic [3:0]           req_slot;
  logic                 req_beat;
  logic [SLOT_BITS-1:0] req_idx;
  logic                 req_in_range;
  logic                 in_fire;
  logic                 out_free;

  // shared walk step
  logic                  walk_valid;
  logic [COUNT_BITS-1:0] walk_cur;
  logic [COUNT_BITS-1:0] walk_new;
  logic                  walk_alarm;
  logic                  walk_commit;
  logic                  load_ack, load_alarm, load_done;

  assign req_mode     = s_axis_tdata[1:0];
  assign req_slot     = s_axis_tdata[5:2];
  assign req_beat     = s_axis_tdata[6];
  assign req_idx      = SLOT_BITS'(req_slot);
  assign req_in_range = (32'(req_slot) < 32'(MAX_SLOTS));

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // one slot per unstalled cycle: clear on beat, else saturating increment; compare
  assign walk_valid = slot_valid[walk_idx];
  assign walk_cur   = missed_count[walk_idx];
  always_comb begin
    if (beat_flag[walk_idx]) begin
      walk_new = '0;
    end else if (walk_cur == {COUNT_BITS{1'b1}}) begin
      walk_new = walk_cur;
    end else begin
      walk_new = walk_cur + 1'b1;
    end
  end
  assign walk_alarm = walk_valid && (32'(walk_new) > 32'(alarm_limit));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    load_ack    = 1'b0;
    load_alarm  = 1'b0;
    load_done   = 1'b0;
    walk_commit = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (req_mode == MODE_TICK) ? S_WALK : S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          load_ack   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        // hold the step while an alarm cannot be handed on
        if (!walk_alarm || out_free) begin
          walk_commit = 1'b1;
          load_alarm  = walk_alarm;
          if (walk_idx == '0) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_done  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_limit <= 16'd10;
    end else if (cfg_we) begin
      alarm_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ack_slot <= req_slot;
    end
    if (in_fire && req_mode == MODE_TICK) begin
      walk_idx <= SLOT_BITS'(MAX_SLOTS - 1);
    end else if (walk_commit && walk_idx != '0) begin
      walk_idx <= walk_idx - 1'b1;
    end
  end

  // valid bits reset; flag and count are always cleared by registration
  // before a walk can use them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (in_fire && req_in_range) begin
      if (req_mode == MODE_REGISTER) begin
        slot_valid[req_idx] <= 1'b1;
      end else if (req_mode == MODE_REMOVE) begin
        slot_valid[req_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && req_in_range && req_mode == MODE_REGISTER) begin
      beat_flag[req_idx]    <= 1'b0;
      missed_count[req_idx] <= '0;
    end else if (in_fire && req_in_range && req_mode == MODE_HEARTBEAT &&
                 slot_valid[req_idx]) begin
      beat_flag[req_idx] <= req_beat;
    end else if (walk_commit && walk_valid) begin
      beat_flag[walk_idx]    <= 1'b0;
      missed_count[walk_idx] <= walk_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ack || load_alarm || load_done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ack) begin
      out_kind   <= KIND_ACK;
      out_slot   <= ack_slot;
      out_missed <= '0;
      out_last   <= 1'b1;
    end else if (load_alarm) begin
      out_kind   <= KIND_ALARM;
      out_slot   <= 4'(walk_idx);
      out_missed <= 16'(walk_new);
      out_last   <= 1'b0;
    end else if (load_done) begin
      out_kind   <= KIND_DONE;
      out_slot   <= '0;
      out_missed <= '0;
      out_last   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_missed, out_slot};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DONE |-> out_last)
    else $error("tick-finished result without last");

  a_alarm_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ALARM |-> !out_last)
    else $error("alarm result marked last");

  a_alarm_loaded: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && walk_commit && walk_alarm |=> out_valid && out_kind == KIND_ALARM)
    else $error("alarm step did not load the output register");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");
`endif

endmodule
